// ----- hw/rtl/mett_pkg.sv -----
package mett_pkg;

  // Field widths
  localparam int BusW     = 1;
  localparam int IdW      = 11;
  localparam int AngleW   = 13;
  localparam int SpeedW   = 16;
  localparam int CurrentW = 16;
  localparam int SlotW    = 3;
  localparam int RateW    = 14;
  localparam int TurnW    = 32;
  localparam int TotalW   = 48;
  localparam int CountW   = 8;

  // One turn is a power of two, so the angle needs no reduction and
  // turns times counts-per-turn is a shift
  localparam int CountsPerTurn = 1 << AngleW;
  localparam int HalfTurn      = CountsPerTurn / 2;
  localparam int DiffW         = AngleW + 2;

  localparam int MotorSlotsDefault = 8;

  // Group layout
  localparam int GroupASize = 3;
  localparam int GroupBSize = 3;
  localparam int GroupCSize = 2;
  localparam int GroupBFirst = GroupASize;
  localparam int GroupCFirst = GroupASize + GroupBSize;

  // Configuration port
  localparam int DataW = 32;
  localparam int AddrW = 4;
  localparam logic [1:0] RegBaseA = 2'd0;
  localparam logic [1:0] RegBaseB = 2'd1;
  localparam logic [1:0] RegBaseC = 2'd2;
  localparam logic [1:0] RegCalib = 2'd3;

  localparam logic [IdW-1:0]    BaseAReset = IdW'(513);
  localparam logic [IdW-1:0]    BaseBReset = IdW'(517);
  localparam logic [IdW-1:0]    BaseCReset = IdW'(513);
  localparam logic [CountW-1:0] CalibReset = CountW'(50);
  localparam logic [CountW-1:0] CountMax   = '1;

  typedef struct packed {
    logic [IdW-1:0]    base_a;
    logic [IdW-1:0]    base_b;
    logic [IdW-1:0]    base_c;
    logic [CountW-1:0] calib_frames;
  } cfg_t;

  typedef struct packed {
    logic             hit;
    logic [SlotW-1:0] slot;
  } slot_map_t;

endpackage

// ----- hw/rtl/mett_cfg.sv -----
module mett_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mett_pkg::AddrW-1:0]     paddr,
  input  logic [mett_pkg::DataW-1:0]     pwdata,
  output logic [mett_pkg::DataW-1:0]     prdata,
  output logic                           pready,
  output mett_pkg::cfg_t                 cfg
);
  import mett_pkg::*;

  logic       wr;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];

  // Write the selected register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_a       <= BaseAReset;
      cfg.base_b       <= BaseBReset;
      cfg.base_c       <= BaseCReset;
      cfg.calib_frames <= CalibReset;
    end else if (wr) begin
      unique case (reg_sel)
        RegBaseA: cfg.base_a       <= pwdata[IdW-1:0];
        RegBaseB: cfg.base_b       <= pwdata[IdW-1:0];
        RegBaseC: cfg.base_c       <= pwdata[IdW-1:0];
        RegCalib: cfg.calib_frames <= pwdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_sel)
      RegBaseA: prdata = DataW'(cfg.base_a);
      RegBaseB: prdata = DataW'(cfg.base_b);
      RegBaseC: prdata = DataW'(cfg.base_c);
      RegCalib: prdata = DataW'(cfg.calib_frames);
      default:  prdata = '0;
    endcase
  end

endmodule

// ----- hw/rtl/mett_slot_map.sv -----
module mett_slot_map #(
  parameter int MOTOR_SLOTS = mett_pkg::MotorSlotsDefault
) (
  input  logic                        bus_select,
  input  logic [mett_pkg::IdW-1:0]    frame_id,
  input  mett_pkg::cfg_t              cfg,
  output mett_pkg::slot_map_t         map
);
  import mett_pkg::*;

  logic [IdW:0] off_a;
  logic [IdW:0] off_b;
  logic [IdW:0] off_c;
  logic         in_a;
  logic         in_b;
  logic         in_c;
  logic         found;
  logic [SlotW-1:0] slot;

  // Offset from each group base; the top bit is the borrow
  assign off_a = {1'b0, frame_id} - {1'b0, cfg.base_a};
  assign off_b = {1'b0, frame_id} - {1'b0, cfg.base_b};
  assign off_c = {1'b0, frame_id} - {1'b0, cfg.base_c};

  assign in_a = !off_a[IdW] && (off_a < (IdW + 1)'(GroupASize));
  assign in_b = !off_b[IdW] && (off_b < (IdW + 1)'(GroupBSize));
  assign in_c = !off_c[IdW] && (off_c < (IdW + 1)'(GroupCSize));

  // Group A wins over group B on the first bus
  always_comb begin
    found = 1'b0;
    slot  = '0;
    if (!bus_select) begin
      if (in_a) begin
        found = 1'b1;
        slot  = off_a[SlotW-1:0];
      end else if (in_b) begin
        found = 1'b1;
        slot  = SlotW'(GroupBFirst) + off_b[SlotW-1:0];
      end
    end else if (in_c) begin
      found = 1'b1;
      slot  = SlotW'(GroupCFirst) + off_c[SlotW-1:0];
    end
  end

  // Drop slots the build does not provide
  assign map.hit  = found && (32'(slot) < MOTOR_SLOTS);
  assign map.slot = slot;

endmodule

// ----- hw/rtl/mett_track.sv -----
module mett_track #(
  parameter int MOTOR_SLOTS = mett_pkg::MotorSlotsDefault
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              update,
  input  logic [mett_pkg::SlotW-1:0]        slot,
  input  logic [mett_pkg::AngleW-1:0]       angle,
  input  logic [mett_pkg::CountW-1:0]       calib_frames,
  output logic                              calibrating,
  output logic signed [mett_pkg::RateW-1:0] position_rate,
  output logic signed [mett_pkg::TurnW-1:0] turn_count,
  output logic signed [mett_pkg::TotalW-1:0] total_position
);
  import mett_pkg::*;

  logic [CountW-1:0] frame_counter [MOTOR_SLOTS];
  logic [AngleW-1:0] offset_angle  [MOTOR_SLOTS];
  logic [AngleW-1:0] last_angle    [MOTOR_SLOTS];
  logic [TurnW-1:0]  turns         [MOTOR_SLOTS];

  logic [CountW-1:0]       cnt_rd;
  logic [AngleW-1:0]       off_rd;
  logic [AngleW-1:0]       last_rd;
  logic [TurnW-1:0]        turns_rd;
  logic [CountW-1:0]       cnt_next;
  logic [AngleW-1:0]       off_next;
  logic [TurnW-1:0]        turns_next;
  logic signed [DiffW-1:0] diff;
  logic signed [DiffW-1:0] rate;
  logic signed [DiffW-1:0] delta;

  // Select the slot's state
  always_comb begin
    cnt_rd   = '0;
    off_rd   = '0;
    last_rd  = '0;
    turns_rd = '0;
    for (int i = 0; i < MOTOR_SLOTS; i++) begin
      if (32'(slot) == i) begin
        cnt_rd   = frame_counter[i];
        off_rd   = offset_angle[i];
        last_rd  = last_angle[i];
        turns_rd = turns[i];
      end
    end
  end

  // Capture the offset or unwrap across the half-turn threshold
  always_comb begin
    calibrating = cnt_rd <= calib_frames;
    cnt_next    = (cnt_rd == CountMax) ? cnt_rd : cnt_rd + CountW'(1);
    diff        = $signed({2'b00, angle}) - $signed({2'b00, last_rd});
    off_next    = off_rd;
    turns_next  = turns_rd;
    rate        = '0;
    if (calibrating) begin
      off_next = angle;
    end else if (diff > $signed(DiffW'(HalfTurn))) begin
      turns_next = turns_rd - TurnW'(1);
      rate       = diff - $signed(DiffW'(CountsPerTurn));
    end else if (diff < -$signed(DiffW'(HalfTurn))) begin
      turns_next = turns_rd + TurnW'(1);
      rate       = diff + $signed(DiffW'(CountsPerTurn));
    end else begin
      rate = diff;
    end
  end

  // Total position: turns shifted by one turn plus the angle past the offset
  assign delta          = $signed({2'b00, angle}) - $signed({2'b00, off_next});
  assign position_rate  = rate[RateW-1:0];
  assign turn_count     = $signed(turns_next);
  assign total_position = $signed({{(TotalW - TurnW - AngleW){turns_next[TurnW-1]}},
                                   turns_next, {AngleW{1'b0}}})
                        + $signed({{(TotalW - DiffW){delta[DiffW-1]}}, delta});

  // Write back the slot's state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MOTOR_SLOTS; i++) begin
        frame_counter[i] <= '0;
        offset_angle[i]  <= '0;
        last_angle[i]    <= '0;
        turns[i]         <= '0;
      end
    end else if (update) begin
      for (int i = 0; i < MOTOR_SLOTS; i++) begin
        if (32'(slot) == i) begin
          frame_counter[i] <= cnt_next;
          offset_angle[i]  <= off_next;
          last_angle[i]    <= angle;
          turns[i]         <= turns_next;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/motor_encoder_multiturn_tracker_top.sv -----
// A word passes from the input register to the result register; an output stall holds it in the input register.
// Throughput: one word per cycle while the output is not stalled; each word's per-slot state is written back
// in the same cycle that its result is registered, so words for the same motor may follow each other directly.
// Frames whose ID matches no slot are dropped without a result.
// Synchronous active-high reset clears all slot state and restores register defaults.
module motor_encoder_multiturn_tracker_top #(
  parameter int MOTOR_SLOTS = mett_pkg::MotorSlotsDefault
) (
  input  logic                         clk,
  input  logic                         rst,
  // frame_id[10:0], encoder_raw[23:11], speed_raw[39:24], current_raw[55:40]
  input  logic [55:0]                  s_tdata,
  // bus_select[0]
  input  logic                         s_tuser,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // position_rate[13:0], turn_count[45:14], total_position[93:46],
  // speed_out[109:94], current_out[125:110], zero[127:126]
  output logic [127:0]                 m_tdata,
  // motor_slot[2:0], calibrating[3]
  output logic [3:0]                   m_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mett_pkg::AddrW-1:0]   paddr,
  input  logic [mett_pkg::DataW-1:0]   pwdata,
  output logic [mett_pkg::DataW-1:0]   prdata,
  output logic                         pready
);
  import mett_pkg::*;

  cfg_t      cfg;
  slot_map_t map;

  logic                in_valid;
  logic                in_bus;
  logic [IdW-1:0]      in_id;
  logic [AngleW-1:0]   in_angle;
  logic [SpeedW-1:0]   in_speed;
  logic [CurrentW-1:0] in_current;

  logic out_free;
  logic in_done;
  logic update;

  logic                     calibrating;
  logic signed [RateW-1:0]  position_rate;
  logic signed [TurnW-1:0]  turn_count;
  logic signed [TotalW-1:0] total_position;

  mett_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake: an unmatched word leaves at once, a matched one when the output is free
  assign out_free = !m_tvalid || m_tready;
  assign in_done  = in_valid && (!map.hit || out_free);
  assign update   = in_valid && map.hit && out_free;
  assign s_tready = !in_valid || in_done;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_bus     <= s_tuser;
      in_id      <= s_tdata[10:0];
      in_angle   <= s_tdata[23:11];
      in_speed   <= s_tdata[39:24];
      in_current <= s_tdata[55:40];
    end
  end

  mett_slot_map #(
    .MOTOR_SLOTS (MOTOR_SLOTS)
  ) u_slot_map (
    .bus_select (in_bus),
    .frame_id   (in_id),
    .cfg        (cfg),
    .map        (map)
  );

  mett_track #(
    .MOTOR_SLOTS (MOTOR_SLOTS)
  ) u_track (
    .clk            (clk),
    .rst            (rst),
    .update         (update),
    .slot           (map.slot),
    .angle          (in_angle),
    .calib_frames   (cfg.calib_frames),
    .calibrating    (calibrating),
    .position_rate  (position_rate),
    .turn_count     (turn_count),
    .total_position (total_position)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (update) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (update) begin
      m_tdata <= {2'b00, in_current, in_speed, total_position, turn_count, position_rate};
      m_tuser <= {calibrating, map.slot};
    end
  end

endmodule

// ----- sim/tb_motor_encoder_multiturn_tracker_top.sv -----
module tb_motor_encoder_multiturn_tracker_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mett_pkg::*;

  typedef struct {
    logic                bus;
    logic [IdW-1:0]      id;
    logic [AngleW-1:0]   angle;
    logic [SpeedW-1:0]   speed;
    logic [CurrentW-1:0] current;
  } frame_t;

  typedef struct {
    logic [SlotW-1:0]    slot;
    logic                calib;
    logic [RateW-1:0]    rate;
    logic [TurnW-1:0]    turns;
    logic [TotalW-1:0]   total;
    logic [SpeedW-1:0]   speed;
    logic [CurrentW-1:0] current;
  } report_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic [55:0]        s_tdata = '0;
  logic               s_tuser = 1'b0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [127:0]       m_tdata;
  logic [3:0]         m_tuser;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [AddrW-1:0]   paddr = '0;
  logic [DataW-1:0]   pwdata = '0;
  logic [DataW-1:0]   prdata;
  logic               pready;

  motor_encoder_multiturn_tracker_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the register file and of the per-motor tracking state
  cfg_t              tracker_cfg;
  logic [CountW-1:0] slot_frames [MotorSlotsDefault];
  logic [AngleW-1:0] zero_angle  [MotorSlotsDefault];
  logic [AngleW-1:0] prev_angle  [MotorSlotsDefault];
  logic [TurnW-1:0]  turn_ctr    [MotorSlotsDefault];

  // Last angle sent per motor, used only to shape the stimulus
  logic [AngleW-1:0] sent_angle  [MotorSlotsDefault];

  frame_t  frame_backlog[$];
  report_t expected_reports[$];
  frame_t  frame_on_bus;
  report_t seen_report;
  int      send_gap = 0;
  int      recv_gap = 0;
  int      frames_accepted = 0;
  int      mismatch_count = 0;
  bit      calm_stretch = 1'b0;
  bit      rx_hold_off = 1'b0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  function automatic int idle_gap();
    int r;
    if (calm_stretch) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int group_index(input logic [IdW-1:0] id, input logic [IdW-1:0] base,
                                     input int n);
    int k;
    k = int'(id) - int'(base);
    return (k >= 0 && k < n) ? k : -1;
  endfunction

  // Map the frame to a motor, advance that motor's tracker and queue its report
  function automatic void track_frame(input frame_t f);
    int      k;
    int      slot;
    int      diff;
    logic    calib;
    longint  pos;
    report_t r;
    slot = -1;
    if (!f.bus) begin
      k = group_index(f.id, tracker_cfg.base_a, GroupASize);
      if (k >= 0) begin
        slot = k;
      end else begin
        k = group_index(f.id, tracker_cfg.base_b, GroupBSize);
        if (k >= 0) slot = GroupBFirst + k;
      end
    end else begin
      k = group_index(f.id, tracker_cfg.base_c, GroupCSize);
      if (k >= 0) slot = GroupCFirst + k;
    end
    if (slot < 0 || slot >= MotorSlotsDefault) return;

    calib = (slot_frames[slot] <= tracker_cfg.calib_frames);
    if (slot_frames[slot] != CountMax) slot_frames[slot]++;

    diff = 0;
    if (calib) begin
      zero_angle[slot] = f.angle;
    end else begin
      diff = int'(f.angle) - int'(prev_angle[slot]);
      if (diff > HalfTurn) begin
        turn_ctr[slot] = turn_ctr[slot] - 1;
        diff = diff - CountsPerTurn;
      end else if (diff < -HalfTurn) begin
        turn_ctr[slot] = turn_ctr[slot] + 1;
        diff = diff + CountsPerTurn;
      end
    end
    prev_angle[slot] = f.angle;

    pos = longint'($signed(turn_ctr[slot])) * CountsPerTurn
        + longint'(f.angle) - longint'(zero_angle[slot]);

    r.slot    = SlotW'(slot);
    r.calib   = calib;
    r.rate    = RateW'(diff);
    r.turns   = turn_ctr[slot];
    r.total   = TotalW'(pos);
    r.speed   = f.speed;
    r.current = f.current;
    expected_reports.push_back(r);
  endfunction

  task automatic check_report(input report_t got, input report_t want);
    if (got.slot !== want.slot)
      report_mismatch("motor_slot", 64'(got.slot), 64'(want.slot));
    if (got.calib !== want.calib)
      report_mismatch("calibrating", 64'(got.calib), 64'(want.calib));
    if (got.rate !== want.rate)
      report_mismatch("position_rate", 64'(got.rate), 64'(want.rate));
    if (got.turns !== want.turns)
      report_mismatch("turn_count", 64'(got.turns), 64'(want.turns));
    if (got.total !== want.total)
      report_mismatch("total_position", 64'(got.total), 64'(want.total));
    if (got.speed !== want.speed)
      report_mismatch("speed_out", 64'(got.speed), 64'(want.speed));
    if (got.current !== want.current)
      report_mismatch("current_out", 64'(got.current), 64'(want.current));
  endtask

  // Sender: offer queued words, with idle gaps between them
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        track_frame(frame_on_bus);
        frames_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (frame_backlog.size() != 0) begin
          frame_on_bus = frame_backlog.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {frame_on_bus.current, frame_on_bus.speed,
                       frame_on_bus.angle, frame_on_bus.id};
          s_tuser  <= frame_on_bus.bus;
          send_gap = idle_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result word against the oldest expectation, stall at random
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        seen_report.rate    = m_tdata[13:0];
        seen_report.turns   = m_tdata[45:14];
        seen_report.total   = m_tdata[93:46];
        seen_report.speed   = m_tdata[109:94];
        seen_report.current = m_tdata[125:110];
        seen_report.slot    = m_tuser[2:0];
        seen_report.calib   = m_tuser[3];
        if (expected_reports.size() == 0)
          report_mismatch("unexpected result word", 64'(seen_report.slot), '0);
        else
          check_report(seen_report, expected_reports.pop_front());
      end
      if (rx_hold_off) begin
        m_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        recv_gap = idle_gap();
      end
    end
  end

  // Hold the receiver off for a long stretch so the block backs up to its input
  initial begin
    while (frames_accepted < 500) @(negedge clk);
    rx_hold_off = 1'b1;
    repeat (300) @(negedge clk);
    rx_hold_off = 1'b0;
  end

  initial begin
    #12_000_000;
    $display("[motor_encoder_multiturn_tracker_top] ERROR");
    $finish;
  end

  task automatic write_reg(input logic [1:0] idx, input logic [DataW-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegBaseA: tracker_cfg.base_a       = value[IdW-1:0];
      RegBaseB: tracker_cfg.base_b       = value[IdW-1:0];
      RegBaseC: tracker_cfg.base_c       = value[IdW-1:0];
      RegCalib: tracker_cfg.calib_frames = value[CountW-1:0];
      default: ;
    endcase
  endtask

  // Wait until every word is sent and every report is back, then let the pipe drain
  task automatic settle();
    int n;
    n = 0;
    while ((frame_backlog.size() != 0 || s_tvalid || expected_reports.size() != 0)
           && n < 20000) begin
      @(negedge clk);
      n++;
    end
    if (expected_reports.size() != 0) begin
      report_mismatch("missing result words", 64'(expected_reports.size()), '0);
      expected_reports.delete();
    end
    repeat (6) @(negedge clk);
  endtask

  function automatic frame_t feedback_frame(input int bus, input int id, input int angle,
                                            input int speed, input int current);
    frame_t f;
    f.bus     = 1'(bus);
    f.id      = IdW'(id);
    f.angle   = AngleW'(angle);
    f.speed   = SpeedW'(speed);
    f.current = CurrentW'(current);
    return f;
  endfunction

  // Mostly frames for configured motors with plausible angle steps, some noise
  function automatic frame_t random_frame();
    frame_t f;
    int     slot;
    int     pick;
    int     step;
    f.speed   = SpeedW'($urandom);
    f.current = CurrentW'($urandom);
    if ($urandom_range(0, 99) < 15) begin
      f.bus   = 1'($urandom_range(0, 1));
      f.id    = IdW'($urandom);
      f.angle = AngleW'($urandom);
      return f;
    end
    slot = ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(0, MotorSlotsDefault - 1);
    if (slot < GroupBFirst) begin
      f.bus = 1'b0;
      f.id  = IdW'(tracker_cfg.base_a + slot);
    end else if (slot < GroupCFirst) begin
      f.bus = 1'b0;
      f.id  = IdW'(tracker_cfg.base_b + slot - GroupBFirst);
    end else begin
      f.bus = 1'b1;
      f.id  = IdW'(tracker_cfg.base_c + slot - GroupCFirst);
    end
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      f.angle = AngleW'(int'(sent_angle[slot]) + int'($urandom_range(0, 200)) - 100);
    end else if (pick < 60) begin
      f.angle = AngleW'(int'(sent_angle[slot]) + int'($urandom_range(0, 8000)) - 4000);
    end else if (pick < 75) begin
      case ($urandom_range(0, 5))
        0: step = HalfTurn - 1;
        1: step = HalfTurn;
        2: step = HalfTurn + 1;
        3: step = -HalfTurn + 1;
        4: step = -HalfTurn;
        default: step = -HalfTurn - 1;
      endcase
      f.angle = AngleW'(int'(sent_angle[slot]) + step);
    end else if (pick < 92) begin
      f.angle = AngleW'($urandom);
    end else begin
      f.angle = $urandom_range(0, 1) ? '1 : '0;
    end
    sent_angle[slot] = f.angle;
    return f;
  endfunction

  task automatic run_phase(input logic [IdW-1:0] a, input logic [IdW-1:0] b,
                           input logic [IdW-1:0] c, input logic [CountW-1:0] calib,
                           input int count, input bit calm);
    write_reg(RegBaseA, DataW'(a));
    write_reg(RegBaseB, DataW'(b));
    write_reg(RegBaseC, DataW'(c));
    write_reg(RegCalib, DataW'(calib));
    @(negedge clk);
    calm_stretch = calm;
    repeat (count) frame_backlog.push_back(random_frame());
    settle();
  endtask

  initial begin
    logic [IdW-1:0] rand_base;
    tracker_cfg.base_a       = BaseAReset;
    tracker_cfg.base_b       = BaseBReset;
    tracker_cfg.base_c       = BaseCReset;
    tracker_cfg.calib_frames = CalibReset;
    for (int i = 0; i < MotorSlotsDefault; i++) begin
      slot_frames[i] = '0;
      zero_angle[i]  = '0;
      prev_angle[i]  = '0;
      turn_ctr[i]    = '0;
      sent_angle[i]  = '0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: one calibrating frame per motor, then tracking at the wrap edges
    write_reg(RegCalib, 0);
    @(negedge clk);
    frame_backlog.push_back(feedback_frame(0, 513, 0,    'h8000, 'h7fff));
    frame_backlog.push_back(feedback_frame(0, 513, 8191, 'h7fff, 'h8000));
    frame_backlog.push_back(feedback_frame(0, 513, 0,    0,      0));
    frame_backlog.push_back(feedback_frame(0, 513, 4096, 'hffff, 1));
    frame_backlog.push_back(feedback_frame(0, 513, 0,    1,      'hffff));
    frame_backlog.push_back(feedback_frame(0, 513, 4097, 'h5555, 'haaaa));
    frame_backlog.push_back(feedback_frame(0, 513, 1,    'haaaa, 'h5555));
    frame_backlog.push_back(feedback_frame(0, 513, 8191, 'h1234, 'hedcb));
    frame_backlog.push_back(feedback_frame(0, 514, 8191, 2,      3));
    frame_backlog.push_back(feedback_frame(0, 515, 1,    4,      5));
    frame_backlog.push_back(feedback_frame(0, 517, 4096, 6,      7));
    frame_backlog.push_back(feedback_frame(0, 518, 2,    8,      9));
    frame_backlog.push_back(feedback_frame(0, 519, 5000, 10,     11));
    frame_backlog.push_back(feedback_frame(1, 513, 7,    12,     13));
    frame_backlog.push_back(feedback_frame(1, 514, 8190, 14,     15));
    frame_backlog.push_back(feedback_frame(1, 514, 100,  16,     17));
    frame_backlog.push_back(feedback_frame(0, 516, 8191, 18,     19));
    frame_backlog.push_back(feedback_frame(0, 520, 0,    20,     21));
    frame_backlog.push_back(feedback_frame(0, 512, 0,    22,     23));
    frame_backlog.push_back(feedback_frame(0, 0,   0,    24,     25));
    frame_backlog.push_back(feedback_frame(0, 2047, 8191, 26,    27));
    frame_backlog.push_back(feedback_frame(1, 515, 0,    28,     29));
    frame_backlog.push_back(feedback_frame(1, 512, 0,    30,     31));
    frame_backlog.push_back(feedback_frame(1, 517, 0,    32,     33));
    frame_backlog.push_back(feedback_frame(1, 2047, 0,   34,     35));
    frame_backlog.push_back(feedback_frame(0, 515, 4000, 36,     37));
    settle();

    // Random phases across register settings, extremes and overlapping groups included
    run_phase(BaseAReset, BaseBReset, BaseCReset, CalibReset, 300, 1'b0);
    run_phase(IdW'(0), IdW'(2045), IdW'(2046), CountW'(0), 300, 1'b0);
    run_phase(IdW'(2047), IdW'(2047), IdW'(0), CountW'(254), 300, 1'b0);
    run_phase(IdW'(700), IdW'(701), IdW'(700), CountW'(3), 300, 1'b1);
    rand_base = IdW'($urandom);
    run_phase(rand_base, IdW'(rand_base + $urandom_range(0, 4)), IdW'($urandom),
              CountW'($urandom_range(0, 254)), 300, 1'b0);
    // Motor 0 has saturated its frame count by now and must keep tracking
    run_phase(BaseAReset, BaseBReset, BaseCReset, CountW'(254), 300, 1'b0);

    repeat (10) @(negedge clk);
    if (mismatch_count == 0 && expected_reports.size() == 0) begin
      $display("[motor_encoder_multiturn_tracker_top] OK");
    end else begin
      $display("[motor_encoder_multiturn_tracker_top] ERROR");
    end
    $finish;
  end

endmodule

// ----- motor_encoder_multiturn_tracker_top.f -----
hw/rtl/mett_pkg.sv
hw/rtl/mett_cfg.sv
hw/rtl/mett_slot_map.sv
hw/rtl/mett_track.sv
hw/rtl/motor_encoder_multiturn_tracker_top.sv
sim/tb_motor_encoder_multiturn_tracker_top.sv
